FILE: src/kmpp_pkg.sv
package kmpp_pkg;

  localparam int FIFO_DEPTH_DEF = 64;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_HDR_MIN = 1'b0;   // word index of mouse_header_min
  localparam logic [7:0] HDR_MIN_RESET = 8'hF8;

  // item opcodes
  localparam logic OP_LINK = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [7:0] BREAK_BIT = 8'h80;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

  // everything in a result except the popped key, which comes from the RAM
  typedef struct packed {
    logic       key_out_valid;
    logic       keys_waiting;
    logic       key_held;
    logic [7:0] mouse_buttons;
    logic [7:0] mouse_dx;
    logic [7:0] mouse_dy;
    logic       mouse_packet_done;
    logic       mouse_moved;
    logic       key_dropped;
  } res_info_t;

endpackage

FILE: src/kmpp_if.sv
interface kmpp_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface kmpp_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        key_out;
  logic              key_out_valid;
  logic              keys_waiting;
  logic              key_held;
  logic [7:0]        mouse_buttons;
  logic signed [7:0] mouse_dx;
  logic signed [7:0] mouse_dy;
  logic              mouse_packet_done;
  logic              mouse_moved;
  logic              key_dropped;

  modport source (output valid, key_out, key_out_valid, keys_waiting, key_held,
                  mouse_buttons, mouse_dx, mouse_dy, mouse_packet_done, mouse_moved,
                  key_dropped, input ready);
  modport sink   (input valid, key_out, key_out_valid, keys_waiting, key_held,
                  mouse_buttons, mouse_dx, mouse_dy, mouse_packet_done, mouse_moved,
                  key_dropped, output ready);
endinterface

FILE: src/keyboard_mouse_packet_parser.sv
// Keyboard / mouse link decoder with a key FIFO. Each item is either a link
// byte (op 0) or a key pop (op 1) and yields exactly one result beat. In the
// idle phase a byte at or above mouse_header_min (APB register at byte
// address 0, reset 0xF8) opens a three-byte mouse packet (header, X delta,
// Y delta); other bytes are key codes: make codes (bit 7 clear) go into a
// FIFO_DEPTH-entry ring and set key_held, break codes clear it. A make code
// hitting a full FIFO is dropped and flagged; a pop of an empty FIFO returns
// key_out = 0 with key_out_valid low. Throughput is one item per cycle while
// the result side is not stalled: all decode state is updated in the accept
// cycle and the scancodes live in a single-port-read RAM whose registered
// read sits in a pipeline stage on the way to the output register. An output
// register plus the RAM stage let a new item in while a result waits. No
// reset sweep: the key store is never read before it is written.
module keyboard_mouse_packet_parser import kmpp_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  kmpp_item_if.sink          item,
  kmpp_result_if.source      result
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic [7:0]       hdr_min;
  logic             acc;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  res_info_t        info;

  // stage 1: waits on the RAM read
  logic      s1_valid;
  res_info_t s1_info;
  logic      s1_move;

  // output register
  logic      out_valid;
  res_info_t out_info;
  logic [7:0] out_key;

  kmpp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr_min (hdr_min)
  );

  kmpp_ctrl #(.FIFO_DEPTH(FIFO_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .op        (item.op),
    .rx_byte   (item.rx_byte),
    .hdr_min   (hdr_min),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .info      (info)
  );

  kmpp_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM read is issued only on accept, and stage 1 only refills when it
  // empties, so ram_rdata holds for as long as stage 1 stalls.
  assign s1_move    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_move;
  assign acc        = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_info <= info;
    end
    if (s1_move) begin
      out_info <= s1_info;
      out_key  <= s1_info.key_out_valid ? ram_rdata : 8'h00;
    end
  end

  assign result.valid             = out_valid;
  assign result.key_out           = out_key;
  assign result.key_out_valid     = out_info.key_out_valid;
  assign result.keys_waiting      = out_info.keys_waiting;
  assign result.key_held          = out_info.key_held;
  assign result.mouse_buttons     = out_info.mouse_buttons;
  assign result.mouse_dx          = out_info.mouse_dx;
  assign result.mouse_dy          = out_info.mouse_dy;
  assign result.mouse_packet_done = out_info.mouse_packet_done;
  assign result.mouse_moved       = out_info.mouse_moved;
  assign result.key_dropped       = out_info.key_dropped;

endmodule

FILE: src/kmpp_ram.sv
module kmpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/kmpp_cfg.sv
module kmpp_cfg import kmpp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [7:0]         hdr_min
);

  logic hit;

  // word index only; byte offset bits ignored
  assign hit    = (paddr[PADDR_W-1] == REG_HDR_MIN);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_min <= HDR_MIN_RESET;
    end else if (psel && penable && pwrite && hit) begin
      hdr_min <= pwdata[7:0];
    end
  end

  assign prdata = hit ? {{(PDATA_W-8){1'b0}}, hdr_min} : '0;

endmodule

FILE: src/kmpp_ctrl.sv
module kmpp_ctrl import kmpp_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(FIFO_DEPTH),
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       hdr_min,
  output logic             ram_we,
  output logic [PTR_W-1:0] ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic             ram_re,
  output logic [PTR_W-1:0] ram_raddr,
  output res_info_t        info
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  phase_t           phase, phase_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       hdr, hdr_next;
  logic [7:0]       dx, dx_next;
  logic [7:0]       dy, dy_next;
  logic             held, held_next;
  logic             moved, moved_next;
  logic             pop_ok, done, dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      hdr    <= '0;
      dx     <= '0;
      dy     <= '0;
      held   <= 1'b0;
      moved  <= 1'b0;
    end else begin
      phase  <= phase_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      hdr    <= hdr_next;
      dx     <= dx_next;
      dy     <= dy_next;
      held   <= held_next;
      moved  <= moved_next;
    end
  end

  always_comb begin
    phase_next  = phase;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    hdr_next    = hdr;
    dx_next     = dx;
    dy_next     = dy;
    held_next   = held;
    moved_next  = moved;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    pop_ok      = 1'b0;
    done        = 1'b0;
    dropped     = 1'b0;
    if (acc) begin
      if (op == OP_POP) begin
        if (count != '0) begin
          ram_re      = 1'b1;
          pop_ok      = 1'b1;
          rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
          count_next  = count - 1'b1;
        end
      end else begin
        case (phase)
          PH_DX: begin
            dx_next    = rx_byte;
            phase_next = PH_DY;
          end
          PH_DY: begin
            dy_next    = rx_byte;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
            if (rx_byte >= hdr_min) begin
              hdr_next   = rx_byte;
              moved_next = (rx_byte == hdr_min);
              phase_next = PH_DX;
            end else if ((rx_byte & BREAK_BIT) == 8'h00) begin
              // make code
              if (count < CNT_FULL) begin
                ram_we      = 1'b1;
                wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
                count_next  = count + 1'b1;
              end else begin
                dropped = 1'b1;
              end
              held_next = 1'b1;
            end else begin
              held_next = 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign ram_waddr = wr_ptr;
  assign ram_wdata = rx_byte;
  assign ram_raddr = rd_ptr;

  always_comb begin
    info.key_out_valid     = pop_ok;
    info.keys_waiting      = (count_next != '0);
    info.key_held          = held_next;
    info.mouse_buttons     = hdr_next;
    info.mouse_dx          = dx_next;
    info.mouse_dy          = dy_next;
    info.mouse_packet_done = done;
    info.mouse_moved       = moved_next;
    info.key_dropped       = dropped;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("key count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> rd_ptr == wr_ptr)
    else $error("empty fifo with unequal pointers");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    acc && op == OP_POP && count != '0 |=> count == $past(count) - 1'b1)
    else $error("pop did not decrement count");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    dropped |-> count == CNT_FULL && !ram_we)
    else $error("key dropped while fifo not full");

endmodule
